[hdl/scrollback_text_buffer_macros.svh]
// Assertion macros shared by the scrollback buffer modules.
`ifndef SCROLLBACK_TEXT_BUFFER_MACROS_SVH
`define SCROLLBACK_TEXT_BUFFER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SBTB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SBTB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBTB_ASSERT(lbl, clk, rstn, prop, msg)
`define SBTB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/sbtb_pkg.sv]
package sbtb_pkg;

    localparam int MAX_LINES_DEF   = 1024;
    localparam int MAX_COLUMNS_DEF = 128;

    localparam logic [7:0] CODE_CR = 8'd13;
    localparam logic [7:0] CODE_LF = 8'd10;

    localparam logic [1:0] CMD_PUT_CHAR  = 2'd0;
    localparam logic [1:0] CMD_SET_SCROLL = 2'd1;
    localparam logic [1:0] CMD_MOVE_SCROLL = 2'd2;
    localparam logic [1:0] CMD_READ_CELL = 2'd3;

    localparam int         CFG_IDX_W          = 2;
    localparam int         CFG_DATA_W         = 10;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_PER_LINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINES_VISIBLE  = 2'd1;
    localparam logic [7:0] CHARS_PER_LINE_RST = 8'd80;
    localparam logic [9:0] LINES_VISIBLE_RST  = 10'd25;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         char_code;
        logic signed [11:0] scroll_value;
        logic [9:0]         view_row;
        logic [6:0]         view_column;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  scroll_pos;
        logic [9:0]  scroll_max;
        logic [10:0] total_lines;
        logic [7:0]  cell_char;
        logic        cell_valid;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_STORE   = 3'd0,
        OP_NEWLINE = 3'd1,
        OP_NOP     = 3'd2,
        OP_SET     = 3'd3,
        OP_MOVE    = 3'd4,
        OP_READ    = 3'd5
    } t_op_kind;

    typedef struct packed {
        t_op_kind           kind;
        logic [7:0]         char_code;
        logic signed [11:0] scroll_value;
        logic [9:0]         view_row;
        logic [6:0]         view_column;
    } t_op;

endpackage

[hdl/scrollback_text_buffer.sv]
// Channel  | Handshake                 | Payload
// in       | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
// out      | o_out_valid / i_out_ready | o_out_data (t_out_item)
// cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Put-char requests pass the back end states EXEC and RESULT; scroll and
// read-cell requests add SCROLL (view wrap) or RDWAIT (registered RAM read).
// A two-entry queue lets the input side keep accepting while the back end or
// the output register is stalled. No clearing pass after reset: line fill
// is held by the write column for the newest line and written when it closes.
module scrollback_text_buffer #(
    parameter int MaxLines   = sbtb_pkg::MAX_LINES_DEF,
    parameter int MaxColumns = sbtb_pkg::MAX_COLUMNS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  sbtb_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output sbtb_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sbtb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sbtb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [7:0]    r_chars_per_line;
    logic [9:0]    r_lines_visible;
    logic          q_full, q_push, q_valid, q_pop;
    sbtb_pkg::t_op front_op, q_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars_per_line <= sbtb_pkg::CHARS_PER_LINE_RST;
            r_lines_visible  <= sbtb_pkg::LINES_VISIBLE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sbtb_pkg::REG_CHARS_PER_LINE: r_chars_per_line <= i_cfg_data[7:0];
                sbtb_pkg::REG_LINES_VISIBLE:  r_lines_visible  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    sbtb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_op    (front_op)
    );

    sbtb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    sbtb_back #(.MaxLines(MaxLines), .MaxColumns(MaxColumns)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_chars_per_line (r_chars_per_line),
        .i_lines_visible  (r_lines_visible),
        .i_q_valid        (q_valid),
        .i_q_op           (q_op),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_data       (o_out_data)
    );

endmodule

[hdl/sbtb_ram.sv]
module sbtb_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sbtb_front.sv]
module sbtb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sbtb_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output sbtb_pkg::t_op     o_op
);

    logic r_last_cr;
    logic n_last_cr;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // CR/LF pairing only depends on put-char history, so it is resolved here
    always_comb begin
        o_op.char_code    = i_item.char_code;
        o_op.scroll_value = i_item.scroll_value;
        o_op.view_row     = i_item.view_row;
        o_op.view_column  = i_item.view_column;
        n_last_cr         = r_last_cr;
        case (i_item.command)
            sbtb_pkg::CMD_PUT_CHAR: begin
                if (i_item.char_code == sbtb_pkg::CODE_CR) begin
                    o_op.kind = sbtb_pkg::OP_NEWLINE;
                end else if (i_item.char_code == sbtb_pkg::CODE_LF) begin
                    o_op.kind = r_last_cr ? sbtb_pkg::OP_NOP : sbtb_pkg::OP_NEWLINE;
                end else begin
                    o_op.kind = sbtb_pkg::OP_STORE;
                end
                n_last_cr = (i_item.char_code == sbtb_pkg::CODE_CR);
            end
            sbtb_pkg::CMD_SET_SCROLL:  o_op.kind = sbtb_pkg::OP_SET;
            sbtb_pkg::CMD_MOVE_SCROLL: o_op.kind = sbtb_pkg::OP_MOVE;
            default:                   o_op.kind = sbtb_pkg::OP_READ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cr <= 1'b0;
        end else if (o_push) begin
            r_last_cr <= n_last_cr;
        end
    end

endmodule

[hdl/sbtb_queue.sv]
`include "scrollback_text_buffer_macros.svh"

module sbtb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbtb_pkg::t_op i_op,
    output logic          o_full,
    output logic          o_valid,
    output sbtb_pkg::t_op o_op,
    input  logic          i_pop
);

    localparam int PW = sbtb_pkg::QUEUE_PW;
    localparam int CW = $clog2(sbtb_pkg::QUEUE_DEPTH + 1);

    sbtb_pkg::t_op r_slot [sbtb_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(sbtb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `SBTB_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full, "queue push while full")
    `SBTB_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_valid, "queue pop while empty")

endmodule

[hdl/sbtb_back.sv]
`include "scrollback_text_buffer_macros.svh"

module sbtb_back #(
    parameter int MaxLines   = sbtb_pkg::MAX_LINES_DEF,
    parameter int MaxColumns = sbtb_pkg::MAX_COLUMNS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_chars_per_line,
    input  logic [9:0]          i_lines_visible,
    input  logic                i_q_valid,
    input  sbtb_pkg::t_op       i_q_op,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sbtb_pkg::t_out_item o_out_data
);

    localparam int LW = $clog2(MaxLines);
    localparam int DW = LW + 1;
    localparam int MW = (DW > 10) ? DW : 10;
    localparam int SW = ((DW > 12) ? DW : 12) + 1;
    localparam int FW = $clog2(MaxColumns + 1);
    localparam int AW = $clog2(MaxLines * MaxColumns);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_RDWAIT = 5'b00100,
        S_SCROLL = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    function automatic logic [DW-1:0] ring_dist(input logic [LW-1:0] a, input logic [LW-1:0] b);
        if (a >= b) begin
            return DW'(a) - DW'(b);
        end
        return DW'(a) + DW'(MaxLines) - DW'(b);
    endfunction

    function automatic logic [LW-1:0] ring_next(input logic [LW-1:0] a);
        return (DW'(a) + DW'(1) >= DW'(MaxLines)) ? '0 : a + LW'(1);
    endfunction

    t_state          r_state, n_state;
    sbtb_pkg::t_op   r_op;
    logic [LW-1:0]   r_oldest, n_oldest;
    logic [LW-1:0]   r_newest, n_newest;
    logic [LW-1:0]   r_view, n_view;
    logic [FW-1:0]   r_col_pos, n_col_pos;
    logic [LW-1:0]   r_p, n_p;
    logic [LW-1:0]   r_line, n_line;
    logic            r_valid, n_valid;
    logic            r_out_valid;
    sbtb_pkg::t_out_item r_out_data, n_out_data;

    logic [FW-1:0]   eff_width;
    logic [9:0]      eff_rows;
    logic [DW-1:0]   total;
    logic [MW-1:0]   scroll_max;
    logic [DW-1:0]   view_off;
    logic            out_space;
    logic            load_out;

    // new-line outcome from the current pointers
    logic [SW-1:0]   top_u;
    logic            rows_lt;
    logic [LW-1:0]   v1, nn, on, nl_view, nl_oldest;
    logic            ring_full;

    logic signed [SW-1:0] sv_ext, base, posv;
    logic [FW-1:0]   col_inc;
    logic [DW-1:0]   span;
    logic [MW:0]     line_sum;
    logic [DW-1:0]   view_sum;
    logic [FW-1:0]   fill_v;
    logic            cell_ok;

    logic            char_we;
    logic [AW-1:0]   char_waddr, char_raddr;
    logic [7:0]      char_q;
    logic            fill_we;
    logic [FW-1:0]   fill_wdata, fill_q;

    logic [31:0]     pos32, max32, tot32;

    always_comb begin
        if (i_chars_per_line == 8'd0) begin
            eff_width = FW'(1);
        end else if (9'(i_chars_per_line) > 9'(MaxColumns)) begin
            eff_width = FW'(MaxColumns);
        end else begin
            eff_width = FW'(i_chars_per_line);
        end
        eff_rows = (i_lines_visible == 10'd0) ? 10'd1 : i_lines_visible;
    end

    assign total      = ring_dist(r_newest, r_oldest) + DW'(1);
    assign scroll_max = (MW'(total) < MW'(eff_rows)) ? '0 : MW'(total) - MW'(eff_rows);
    assign view_off   = ring_dist(r_view, r_oldest);

    always_comb begin
        top_u = SW'(r_newest) + SW'(1) + SW'(MaxLines) - SW'(eff_rows);
        if (top_u >= SW'(MaxLines)) begin
            top_u = top_u - SW'(MaxLines);
        end
        rows_lt   = SW'(eff_rows) < SW'(MaxLines);
        v1        = (rows_lt && r_view == top_u[LW-1:0]) ? ring_next(r_view) : r_view;
        nn        = ring_next(r_newest);
        on        = ring_next(r_oldest);
        ring_full = (r_oldest == nn);
        nl_oldest = ring_full ? on : r_oldest;
        nl_view   = (ring_full && v1 == r_oldest) ? on : v1;
    end

    assign out_space = !r_out_valid || i_out_ready;
    assign load_out  = (r_state == S_RESULT) && out_space;
    assign o_q_pop   = i_q_valid && ((r_state == S_IDLE) || load_out);

    assign col_inc    = r_col_pos + FW'(1);
    assign char_waddr = AW'(r_newest) * AW'(MaxColumns) + AW'(r_col_pos);
    assign char_raddr = AW'(r_line) * AW'(MaxColumns) + AW'(r_op.view_column);

    always_comb begin
        sv_ext = {{(SW-12){r_op.scroll_value[11]}}, r_op.scroll_value};
        base   = (r_op.kind == sbtb_pkg::OP_MOVE) ? $signed(SW'(view_off)) : '0;
        posv   = base + sv_ext;
        span   = ring_dist(r_newest, r_view);
        line_sum = (MW+1)'(r_view) + (MW+1)'(r_op.view_row);
        if (line_sum >= (MW+1)'(MaxLines)) begin
            line_sum = line_sum - (MW+1)'(MaxLines);
        end
        view_sum = DW'(r_oldest) + DW'(r_p);
        if (view_sum >= DW'(MaxLines)) begin
            view_sum = view_sum - DW'(MaxLines);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_oldest   = r_oldest;
        n_newest   = r_newest;
        n_view     = r_view;
        n_col_pos  = r_col_pos;
        n_p        = r_p;
        n_line     = r_line;
        n_valid    = r_valid;
        char_we    = 1'b0;
        fill_we    = 1'b0;
        fill_wdata = r_col_pos;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_valid = 1'b0;
                n_state = S_RESULT;
                case (r_op.kind)
                    sbtb_pkg::OP_STORE: begin
                        char_we = 1'b1;
                        if (col_inc >= eff_width) begin
                            fill_we    = 1'b1;
                            fill_wdata = col_inc;
                            n_newest   = nn;
                            n_oldest   = nl_oldest;
                            n_view     = nl_view;
                            n_col_pos  = '0;
                        end else begin
                            n_col_pos = col_inc;
                        end
                    end
                    sbtb_pkg::OP_NEWLINE: begin
                        fill_we   = 1'b1;
                        n_newest  = nn;
                        n_oldest  = nl_oldest;
                        n_view    = nl_view;
                        n_col_pos = '0;
                    end
                    sbtb_pkg::OP_SET, sbtb_pkg::OP_MOVE: begin
                        if (posv < 0) begin
                            n_p = '0;
                        end else if (posv > $signed(SW'(scroll_max))) begin
                            n_p = LW'(scroll_max);
                        end else begin
                            n_p = LW'(posv);
                        end
                        n_state = S_SCROLL;
                    end
                    sbtb_pkg::OP_READ: begin
                        n_valid = (MW'(r_op.view_row) <= MW'(span));
                        n_line  = line_sum[LW-1:0];
                        n_state = S_RDWAIT;
                    end
                    default: ;
                endcase
            end
            S_RDWAIT: n_state = S_RESULT;
            S_SCROLL: begin
                n_view  = view_sum[LW-1:0];
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_space) begin
                    n_state = i_q_valid ? S_EXEC : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // the line being written has its fill held in r_col_pos, not in the RAM
    always_comb begin
        fill_v  = (r_line == r_newest) ? r_col_pos : fill_q;
        cell_ok = r_valid && (9'(r_op.view_column) < 9'(eff_width))
                  && (9'(r_op.view_column) < 9'(fill_v));
        pos32 = 32'(view_off);
        max32 = 32'(scroll_max);
        tot32 = 32'(total);
        n_out_data.scroll_pos  = pos32[9:0];
        n_out_data.scroll_max  = max32[9:0];
        n_out_data.total_lines = tot32[10:0];
        n_out_data.cell_char   = cell_ok ? char_q : 8'd0;
        n_out_data.cell_valid  = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_newest    <= '0;
            r_view      <= '0;
            r_col_pos   <= '0;
            r_valid     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_oldest  <= n_oldest;
            r_newest  <= n_newest;
            r_view    <= n_view;
            r_col_pos <= n_col_pos;
            r_valid   <= n_valid;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_line <= n_line;
        if (o_q_pop) begin
            r_op <= i_q_op;
        end
        if (load_out) begin
            r_out_data <= n_out_data;
        end
    end

    sbtb_ram #(.Width(8), .Depth(MaxLines * MaxColumns)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (char_waddr),
        .i_wdata (r_op.char_code),
        .i_raddr (char_raddr),
        .o_rdata (char_q)
    );

    sbtb_ram #(.Width(FW), .Depth(MaxLines)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (r_newest),
        .i_wdata (fill_wdata),
        .i_raddr (r_line),
        .o_rdata (fill_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `SBTB_ASSERT(a_view_in_ring, i_clk, i_rst_n, view_off < total, "view outside stored lines")
    `SBTB_ASSERT(a_col_ok, i_clk, i_rst_n, r_col_pos < FW'(MaxColumns), "column overrun")
    `SBTB_ASSERT(a_pop_free, i_clk, i_rst_n, o_q_pop |-> r_state != S_EXEC, "pop mid-op")

endmodule

[tb/scrollback_checker.sv]
`timescale 1ns / 100ps

module scrollback_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  sbtb_pkg::t_in_item   i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  sbtb_pkg::t_out_item  i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [sbtb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbtb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // shadow copy of the scrollback state
    logic [7:0] cells [0:131071];
    logic [7:0] fill_mark [0:1023];
    logic [9:0] oldest, newest, view_top;
    int         col_pos;
    logic       prev_cr;
    logic [7:0] width_reg;
    logic [9:0] rows_reg;

    sbtb_pkg::t_out_item expected_results[$];

    initial begin
        for (int k = 0; k < 1024; k++) fill_mark[k] = '0;
        oldest = '0;
        newest = '0;
        view_top = '0;
        col_pos = 0;
        prev_cr = 1'b0;
        width_reg = sbtb_pkg::CHARS_PER_LINE_RST;
        rows_reg = sbtb_pkg::LINES_VISIBLE_RST;
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic int line_width();
        if (width_reg == 0) return 1;
        if (width_reg > 128) return 128;
        return int'(width_reg);
    endfunction

    function automatic int view_rows();
        return (rows_reg == 0) ? 1 : int'(rows_reg);
    endfunction

    function automatic int line_count();
        logic [9:0] d;
        d = newest - oldest;
        return int'(d) + 1;
    endfunction

    function automatic int scroll_limit();
        int all_lines;
        all_lines = line_count();
        return (all_lines < view_rows()) ? 0 : all_lines - view_rows();
    endfunction

    function automatic void clamp_view(int pos);
        int p;
        p = (pos < 0) ? 0 : ((pos > scroll_limit()) ? scroll_limit() : pos);
        view_top = oldest + 10'(p);
    endfunction

    function automatic void open_line();
        logic [9:0] top_row;
        logic       drag_view;
        // follow mode: view advances when its last row is the newest line
        top_row = newest + 10'd1 - 10'(view_rows());
        if (view_top == top_row) view_top = view_top + 10'd1;
        newest = newest + 10'd1;
        col_pos = 0;
        if (oldest == newest) begin
            drag_view = (view_top == oldest);
            oldest = oldest + 10'd1;
            if (drag_view) view_top = oldest;
        end
        fill_mark[newest] = '0;
    endfunction

    function automatic sbtb_pkg::t_out_item apply_request(sbtb_pkg::t_in_item req);
        sbtb_pkg::t_out_item res;
        logic [9:0] span, line;
        res = '0;
        case (req.command)
            sbtb_pkg::CMD_PUT_CHAR: begin
                if (req.char_code == sbtb_pkg::CODE_CR
                    || (req.char_code == sbtb_pkg::CODE_LF && !prev_cr)) begin
                    open_line();
                end else if (req.char_code != sbtb_pkg::CODE_LF) begin
                    cells[{newest, 7'(col_pos)}] = req.char_code;
                    col_pos++;
                    fill_mark[newest] = 8'(col_pos);
                    if (col_pos >= line_width()) open_line();
                end
                prev_cr = (req.char_code == sbtb_pkg::CODE_CR);
            end
            sbtb_pkg::CMD_SET_SCROLL: clamp_view(int'(req.scroll_value));
            sbtb_pkg::CMD_MOVE_SCROLL:
                clamp_view(int'(10'(view_top - oldest)) + int'(req.scroll_value));
            default: begin
                span = newest - view_top;
                if (req.view_row <= span) begin
                    line = view_top + req.view_row;
                    res.cell_valid = 1'b1;
                    if (int'(req.view_column) < line_width()
                        && req.view_column < fill_mark[line])
                        res.cell_char = cells[{line, req.view_column}];
                end
            end
        endcase
        res.scroll_pos = view_top - oldest;
        res.scroll_max = 10'(scroll_limit());
        res.total_lines = 11'(line_count());
        return res;
    endfunction

    always @(posedge i_clk) begin
        sbtb_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == sbtb_pkg::REG_CHARS_PER_LINE) width_reg = i_cfg_data[7:0];
                else if (i_cfg_index == sbtb_pkg::REG_LINES_VISIBLE) rows_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(apply_request(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result %p", i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    if (want.scroll_pos !== i_out_data.scroll_pos
                        || want.scroll_max !== i_out_data.scroll_max
                        || want.total_lines !== i_out_data.total_lines
                        || want.cell_char !== i_out_data.cell_char
                        || want.cell_valid !== i_out_data.cell_valid) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, i_out_data);
                    end
                end
            end
            o_pending = expected_results.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk;
    logic       rst_n;
    logic       in_valid, in_ready;
    sbtb_pkg::t_in_item  in_data;
    logic       out_valid, out_ready;
    sbtb_pkg::t_out_item out_data;
    logic       cfg_valid, cfg_ready;
    logic [sbtb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sbtb_pkg::CFG_DATA_W-1:0] cfg_data;
    int         fail_count, pending;
    int         cycles;
    int         idle_pct, stall_pct;

    scrollback_text_buffer i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    scrollback_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

    function automatic sbtb_pkg::t_in_item mk(logic [1:0] cmd, logic [7:0] ch, int sv,
                                              int row, int col);
        sbtb_pkg::t_in_item r;
        r.command = cmd;
        r.char_code = ch;
        r.scroll_value = 12'(sv);
        r.view_row = 10'(row);
        r.view_column = 7'(col);
        return r;
    endfunction

    // random request, put-char share in percent
    function automatic sbtb_pkg::t_in_item random_request(int put_pct);
        sbtb_pkg::t_in_item r;
        int roll;
        r = mk(sbtb_pkg::CMD_PUT_CHAR, 8'($urandom), $urandom, $urandom_range(0, 1022),
               $urandom);
        roll = $urandom_range(0, 99);
        if (roll < put_pct) begin
            r.command = sbtb_pkg::CMD_PUT_CHAR;
            case ($urandom_range(0, 5))
                0: r.char_code = sbtb_pkg::CODE_CR;
                1: r.char_code = sbtb_pkg::CODE_LF;
                2, 3: r.char_code = 8'($urandom_range(32, 126));
                default: ;
            endcase
        end else begin
            r.command = 2'($urandom_range(1, 3));
            if ($urandom_range(0, 1)) r.scroll_value = 12'($urandom_range(0, 40) - 20);
            if ($urandom_range(0, 3) != 0) r.view_row = 10'($urandom_range(0, 30));
            if ($urandom_range(0, 1)) r.view_column = 7'($urandom_range(0, 12));
        end
        return r;
    endfunction

    task automatic send(sbtb_pkg::t_in_item req);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(logic [sbtb_pkg::CFG_IDX_W-1:0] idx, int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = sbtb_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_phase(int width, int rows, int count, int put_pct, int idle, int stall);
        drain();
        write_reg(sbtb_pkg::REG_CHARS_PER_LINE, width);
        write_reg(sbtb_pkg::REG_LINES_VISIBLE, rows);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count) send(random_request(put_pct));
    endtask

    initial begin
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        send(mk(sbtb_pkg::CMD_PUT_CHAR, 8'd65, 0, 0, 0));
        send(mk(sbtb_pkg::CMD_PUT_CHAR, 8'd255, 0, 0, 0));
        send(mk(sbtb_pkg::CMD_PUT_CHAR, 8'd0, 0, 0, 0));
        send(mk(sbtb_pkg::CMD_READ_CELL, 0, 0, 0, 1));
        send(mk(sbtb_pkg::CMD_READ_CELL, 0, 0, 0, 127));
        send(mk(sbtb_pkg::CMD_PUT_CHAR, sbtb_pkg::CODE_CR, 0, 0, 0));
        send(mk(sbtb_pkg::CMD_PUT_CHAR, sbtb_pkg::CODE_LF, 0, 0, 0));    // LF after CR: ignored
        send(mk(sbtb_pkg::CMD_PUT_CHAR, sbtb_pkg::CODE_LF, 0, 0, 0));    // bare LF: new line
        send(mk(sbtb_pkg::CMD_READ_CELL, 0, 0, 1, 0));
        send(mk(sbtb_pkg::CMD_READ_CELL, 0, 0, 5, 0));         // past newest line
        send(mk(sbtb_pkg::CMD_READ_CELL, 0, 0, 1022, 127));
        send(mk(sbtb_pkg::CMD_SET_SCROLL, 0, -2048, 0, 0));
        send(mk(sbtb_pkg::CMD_SET_SCROLL, 0, 2047, 0, 0));
        send(mk(sbtb_pkg::CMD_MOVE_SCROLL, 0, -2048, 0, 0));
        send(mk(sbtb_pkg::CMD_MOVE_SCROLL, 0, 2047, 0, 0));
        for (int k = 0; k < 6; k++) send(mk(sbtb_pkg::CMD_PUT_CHAR, 8'(97 + k), 0, 0, 0));
        // width lowered below the column in use
        drain();
        write_reg(sbtb_pkg::REG_CHARS_PER_LINE, 4);
        send(mk(sbtb_pkg::CMD_PUT_CHAR, 8'd122, 0, 0, 0));
        send(mk(sbtb_pkg::CMD_READ_CELL, 0, 0, 2, 6));
        send(mk(sbtb_pkg::CMD_READ_CELL, 0, 0, 3, 0));

        run_phase(0, 0, 200, 60, 0, 0);
        run_phase(1, 3, 400, 85, 68, 0);     // narrow lines: one character per line
        run_phase(128, 1023, 250, 60, 0, 68);
        run_phase(255, 1, 200, 55, 20, 20);
        run_phase(37, 25, 200, 60, 0, 0);

        drain();
        if (fail_count == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

endmodule
